// ===== design/tpms_pkg.sv =====
// Package for the tracker power mode scheduler: field widths, mode and
// wake cause codes, event opcodes, register indexes and reset values.
// No dependencies.
`default_nettype none

package tpms_pkg;

   localparam int TIME_W  = 32;
   localparam int IVAL_W  = 27;
   localparam int CODE_W  = 3;
   localparam int CNT_W   = 32;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CODE_W-1:0] {
      OP_WAKE      = 3'd0,
      OP_SET_MODE  = 3'd1,
      OP_MOTION    = 3'd2,
      OP_STAT_TMO  = 3'd3,
      OP_SOS       = 3'd4,
      OP_REPORTED  = 3'd5,
      OP_HEARTBEAT = 3'd6,
      OP_QUERY     = 3'd7
   } op_type;

   localparam logic [CODE_W-1:0] MODE_STATIONARY = 3'd0;
   localparam logic [CODE_W-1:0] MODE_MOVING     = 3'd1;
   localparam logic [CODE_W-1:0] MODE_STOPPED    = 3'd2;
   localparam logic [CODE_W-1:0] MODE_SOS        = 3'd3;
   localparam logic [CODE_W-1:0] MODE_DEEP_SLEEP = 3'd4;

   localparam logic [CODE_W-1:0] CAUSE_NONE      = 3'd0;
   localparam logic [CODE_W-1:0] CAUSE_TIMER     = 3'd1;
   localparam logic [CODE_W-1:0] CAUSE_MOTION    = 3'd2;
   localparam logic [CODE_W-1:0] CAUSE_SOS_BTN   = 3'd3;
   localparam logic [CODE_W-1:0] CAUSE_RESET     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MOVING_IVAL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATIONARY_IVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOS_IVAL        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEARTBEAT_IVAL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STOPPED_IVAL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SLEEP       = 3'd5;

   localparam logic [IVAL_W-1:0] RST_MOVING_IVAL     = 27'd300000;
   localparam logic [IVAL_W-1:0] RST_STATIONARY_IVAL = 27'd1800000;
   localparam logic [IVAL_W-1:0] RST_SOS_IVAL        = 27'd60000;
   localparam logic [IVAL_W-1:0] RST_HEARTBEAT_IVAL  = 27'd3600000;
   localparam logic [IVAL_W-1:0] RST_STOPPED_IVAL    = 27'd60000;
   localparam logic [IVAL_W-1:0] RST_MIN_SLEEP       = 27'd1000;

endpackage

`default_nettype wire

// ===== design/tpms_if.sv =====
// Channel interfaces of the tracker power mode scheduler: event requests
// in, status responses out. Depends on tpms_pkg.
`default_nettype none

interface tpms_req_if;
   logic                         valid;
   logic                         ready;
   logic [tpms_pkg::CODE_W-1:0]  operation;
   logic [tpms_pkg::TIME_W-1:0]  now_ms;
   logic [tpms_pkg::CODE_W-1:0]  target_mode;
   logic [tpms_pkg::CODE_W-1:0]  wake_cause_in;

   modport source (output valid, operation, now_ms, target_mode, wake_cause_in,
                   input ready);
   modport sink   (input valid, operation, now_ms, target_mode, wake_cause_in,
                   output ready);
endinterface

interface tpms_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tpms_pkg::CODE_W-1:0]  mode;
   logic                         gps_enabled;
   logic                         cell_fallback;
   logic                         report_due;
   logic                         heartbeat_due;
   logic [tpms_pkg::IVAL_W-1:0]  report_interval_ms;
   logic [tpms_pkg::IVAL_W-1:0]  sleep_ms;
   logic [tpms_pkg::CNT_W-1:0]   reports_total;
   logic [tpms_pkg::CNT_W-1:0]   sos_total;
   logic [tpms_pkg::CODE_W-1:0]  wake_cause;

   modport source (output valid, mode, gps_enabled, cell_fallback, report_due,
                   heartbeat_due, report_interval_ms, sleep_ms, reports_total,
                   sos_total, wake_cause,
                   input ready);
   modport sink   (input valid, mode, gps_enabled, cell_fallback, report_due,
                   heartbeat_due, report_interval_ms, sleep_ms, reports_total,
                   sos_total, wake_cause,
                   output ready);
endinterface

`default_nettype wire

// ===== design/tracker_power_mode_scheduler_unit.sv =====
// Tracker power mode scheduler, top level: event register, state update,
// interval and sleep length logic, response register.
// Depends on tpms_pkg and tpms_if.
//
//   channel   dir  handshake            contents
//   req_bus   in   valid/ready          operation, now_ms, target_mode, wake_cause_in
//   rsp_bus   out  valid/ready          mode, flags, due flags, interval, sleep, counters
//   csr_*     in   write enable only    index 0..5, 27-bit data, no read-back
//
// One transaction per cycle sustained while rsp_bus is not stalled; a response
// passes the event register, then the response register, after its request is
// accepted. The state update plus one 32-bit add, compare and subtract chain
// sets the cycle. A stalled response holds in its register while the next event
// waits in the event register. Reset is synchronous and restores all state and
// configuration; the block takes requests as soon as reset drops.
`default_nettype none

module tracker_power_mode_scheduler_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tpms_req_if.sink                            req_bus,
   tpms_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_write_enable,
   input  wire logic [tpms_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tpms_pkg::IVAL_W-1:0]    csr_write_data
);
   import tpms_pkg::*;

   // configuration
   logic [IVAL_W-1:0] moving_ival_ff, stationary_ival_ff, sos_ival_ff;
   logic [IVAL_W-1:0] heartbeat_ival_ff, stopped_ival_ff, min_sleep_ff;

   // event register
   logic              evt_valid_ff;
   op_type            evt_op_ff;
   logic [TIME_W-1:0] evt_now_ff;
   logic [CODE_W-1:0] evt_target_ff;
   logic [CODE_W-1:0] evt_cause_ff;

   // architectural state
   logic [CODE_W-1:0] mode_ff, mode_in;
   logic              gps_ff, gps_in;
   logic              fallback_ff, fallback_in;
   logic [TIME_W-1:0] last_rep_ff, last_rep_in;
   logic [TIME_W-1:0] last_hb_ff, last_hb_in;
   logic [CNT_W-1:0]  rep_cnt_ff, rep_cnt_in;
   logic [CNT_W-1:0]  sos_cnt_ff, sos_cnt_in;
   logic [CODE_W-1:0] cause_ff, cause_in;

   // response register
   logic              rsp_valid_ff;
   logic [CODE_W-1:0] res_mode_ff;
   logic              res_gps_ff, res_fallback_ff, res_rep_due_ff, res_hb_due_ff;
   logic [IVAL_W-1:0] res_ival_ff, res_sleep_ff;
   logic [CNT_W-1:0]  res_rep_cnt_ff, res_sos_cnt_ff;
   logic [CODE_W-1:0] res_cause_ff;

   logic              advance;
   logic              do_enter;
   logic [CODE_W-1:0] enter_target;
   logic [CODE_W-1:0] cause_sat;
   logic [IVAL_W-1:0] ival;
   logic [TIME_W-1:0] next_rep, next_hb, next_ev, dur_raw;
   logic [IVAL_W-1:0] dur_capped, sleep_len;
   logic              rep_due, hb_due;

   assign advance     = evt_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !reset && (!evt_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ival_ff     <= RST_MOVING_IVAL;
         stationary_ival_ff <= RST_STATIONARY_IVAL;
         sos_ival_ff        <= RST_SOS_IVAL;
         heartbeat_ival_ff  <= RST_HEARTBEAT_IVAL;
         stopped_ival_ff    <= RST_STOPPED_IVAL;
         min_sleep_ff       <= RST_MIN_SLEEP;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MOVING_IVAL:     moving_ival_ff     <= csr_write_data;
            CSR_STATIONARY_IVAL: stationary_ival_ff <= csr_write_data;
            CSR_SOS_IVAL:        sos_ival_ff        <= csr_write_data;
            CSR_HEARTBEAT_IVAL:  heartbeat_ival_ff  <= csr_write_data;
            CSR_STOPPED_IVAL:    stopped_ival_ff    <= csr_write_data;
            CSR_MIN_SLEEP:       min_sleep_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         evt_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         evt_op_ff     <= op_type'(req_bus.operation);
         evt_now_ff    <= req_bus.now_ms;
         evt_target_ff <= req_bus.target_mode;
         evt_cause_ff  <= req_bus.wake_cause_in;
      end
   end

   // next state for the event in the event register
   always_comb begin
      mode_in      = mode_ff;
      gps_in       = gps_ff;
      fallback_in  = fallback_ff;
      last_rep_in  = last_rep_ff;
      last_hb_in   = last_hb_ff;
      rep_cnt_in   = rep_cnt_ff;
      sos_cnt_in   = sos_cnt_ff;
      cause_in     = cause_ff;
      do_enter     = 1'b0;
      enter_target = evt_target_ff;
      cause_sat    = (evt_cause_ff > CAUSE_RESET) ? CAUSE_RESET : evt_cause_ff;

      unique case (evt_op_ff)
         OP_WAKE: begin
            cause_in    = cause_sat;
            last_rep_in = '0;
            last_hb_in  = '0;
            priority if (cause_sat == CAUSE_MOTION) begin
               mode_in = MODE_MOVING;
            end else if (cause_sat == CAUSE_SOS_BTN) begin
               mode_in = MODE_SOS;
            end else begin
               mode_in = MODE_STATIONARY;
            end
         end
         OP_SET_MODE: begin
            do_enter     = (evt_target_ff <= MODE_DEEP_SLEEP);
            enter_target = evt_target_ff;
         end
         OP_MOTION: begin
            do_enter     = (mode_ff == MODE_STATIONARY);
            enter_target = MODE_MOVING;
         end
         OP_STAT_TMO: begin
            do_enter     = (mode_ff == MODE_MOVING);
            enter_target = MODE_STOPPED;
         end
         OP_SOS: begin
            do_enter     = 1'b1;
            enter_target = MODE_SOS;
         end
         OP_REPORTED: begin
            last_rep_in = evt_now_ff;
            rep_cnt_in  = rep_cnt_ff + 1'b1;
         end
         OP_HEARTBEAT: begin
            last_hb_in = evt_now_ff;
         end
         OP_QUERY: ;
      endcase

      if (do_enter) begin
         mode_in = enter_target;
         unique case (enter_target)
            MODE_STATIONARY: begin
               gps_in      = 1'b0;
               fallback_in = 1'b1;
            end
            MODE_MOVING: begin
               gps_in      = 1'b1;
               fallback_in = 1'b0;
            end
            MODE_STOPPED: gps_in = 1'b1;
            MODE_SOS: begin
               gps_in     = 1'b1;
               sos_cnt_in = sos_cnt_ff + 1'b1;
            end
            default: ;   // deep sleep keeps both flags
         endcase
      end
   end

   // interval, due flags and sleep length after the update
   always_comb begin
      unique case (mode_in)
         MODE_MOVING:  ival = moving_ival_ff;
         MODE_STOPPED: ival = stopped_ival_ff;
         MODE_SOS:     ival = sos_ival_ff;
         default:      ival = stationary_ival_ff;
      endcase

      next_rep = last_rep_in + TIME_W'(ival);
      next_hb  = last_hb_in + TIME_W'(heartbeat_ival_ff);
      next_ev  = (next_rep < next_hb) ? next_rep : next_hb;
      dur_raw  = (next_ev > evt_now_ff) ? (next_ev - evt_now_ff) : TIME_W'(ival);
      dur_capped = (dur_raw > TIME_W'(ival)) ? ival : dur_raw[IVAL_W-1:0];
      sleep_len  = (dur_capped < min_sleep_ff) ? min_sleep_ff : dur_capped;

      rep_due = ((evt_now_ff - last_rep_in) >= TIME_W'(ival));
      hb_due  = ((evt_now_ff - last_hb_in) >= TIME_W'(heartbeat_ival_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_STATIONARY;
         gps_ff      <= 1'b0;
         fallback_ff <= 1'b0;
         last_rep_ff <= '0;
         last_hb_ff  <= '0;
         rep_cnt_ff  <= '0;
         sos_cnt_ff  <= '0;
         cause_ff    <= CAUSE_RESET;
      end else if (advance) begin
         mode_ff     <= mode_in;
         gps_ff      <= gps_in;
         fallback_ff <= fallback_in;
         last_rep_ff <= last_rep_in;
         last_hb_ff  <= last_hb_in;
         rep_cnt_ff  <= rep_cnt_in;
         sos_cnt_ff  <= sos_cnt_in;
         cause_ff    <= cause_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_mode_ff     <= mode_in;
         res_gps_ff      <= gps_in;
         res_fallback_ff <= fallback_in;
         res_rep_due_ff  <= rep_due;
         res_hb_due_ff   <= hb_due;
         res_ival_ff     <= ival;
         res_sleep_ff    <= sleep_len;
         res_rep_cnt_ff  <= rep_cnt_in;
         res_sos_cnt_ff  <= sos_cnt_in;
         res_cause_ff    <= cause_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.mode               = res_mode_ff;
   assign rsp_bus.gps_enabled        = res_gps_ff;
   assign rsp_bus.cell_fallback      = res_fallback_ff;
   assign rsp_bus.report_due         = res_rep_due_ff;
   assign rsp_bus.heartbeat_due      = res_hb_due_ff;
   assign rsp_bus.report_interval_ms = res_ival_ff;
   assign rsp_bus.sleep_ms           = res_sleep_ff;
   assign rsp_bus.reports_total      = res_rep_cnt_ff;
   assign rsp_bus.sos_total          = res_sos_cnt_ff;
   assign rsp_bus.wake_cause         = res_cause_ff;

endmodule

`default_nettype wire

// ===== design/tpms_checker.sv =====
// Port-level checks for the tracker power mode scheduler, bound to the top
// level. Depends on tpms_pkg and tracker_power_mode_scheduler_unit.
`default_nettype none

module tpms_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [tpms_pkg::CODE_W-1:0]   rsp_mode,
   input wire logic [tpms_pkg::CODE_W-1:0]   rsp_wake_cause,
   input wire logic [tpms_pkg::CNT_W-1:0]    rsp_sos_total
);
   import tpms_pkg::*;

   // a stalled response keeps its mode and SOS count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode) &&
         $stable(rsp_sos_total))
      else $error("stalled response changed");

   // after an accepted request passes the event register, a response is valid, new or waiting
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("accepted request produced no response");

   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode <= MODE_DEEP_SLEEP && rsp_wake_cause <= CAUSE_RESET)
      else $error("mode or wake cause out of range");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind tracker_power_mode_scheduler_unit tpms_checker u_tpms_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_mode       (rsp_bus.mode),
   .rsp_wake_cause (rsp_bus.wake_cause),
   .rsp_sos_total  (rsp_bus.sos_total)
);

`default_nettype wire
